// ----- design/sct_pkg.sv -----
`timescale 1ns / 1ps

package sct_pkg;

  // defaults for the top-level parameters
  localparam int unsigned LineMaxDefault  = 1024;
  localparam int unsigned CharBitsDefault = 16;

  // fixed field widths on the ports
  localparam int unsigned CharW   = 16;
  localparam int unsigned OutOffW = 11;

  // characters with a meaning of their own
  localparam logic [CharW-1:0] ChTab    = 16'h0009;
  localparam logic [CharW-1:0] ChCr     = 16'h000D;
  localparam logic [CharW-1:0] ChSpace  = 16'h0020;
  localparam logic [CharW-1:0] ChBang   = 16'h0021;
  localparam logic [CharW-1:0] ChDollar = 16'h0024;
  localparam logic [CharW-1:0] ChAmp    = 16'h0026;
  localparam logic [CharW-1:0] ChApos   = 16'h0027;
  localparam logic [CharW-1:0] ChLParen = 16'h0028;
  localparam logic [CharW-1:0] ChRParen = 16'h0029;
  localparam logic [CharW-1:0] ChStar   = 16'h002A;
  localparam logic [CharW-1:0] ChPlus   = 16'h002B;
  localparam logic [CharW-1:0] ChComma  = 16'h002C;
  localparam logic [CharW-1:0] ChDash   = 16'h002D;
  localparam logic [CharW-1:0] ChDot    = 16'h002E;
  localparam logic [CharW-1:0] ChSlash  = 16'h002F;
  localparam logic [CharW-1:0] ChZero   = 16'h0030;
  localparam logic [CharW-1:0] ChNine   = 16'h0039;
  localparam logic [CharW-1:0] ChColon  = 16'h003A;
  localparam logic [CharW-1:0] ChLt     = 16'h003C;
  localparam logic [CharW-1:0] ChEq     = 16'h003D;
  localparam logic [CharW-1:0] ChGt     = 16'h003E;
  localparam logic [CharW-1:0] ChUpA    = 16'h0041;
  localparam logic [CharW-1:0] ChUpD    = 16'h0044;
  localparam logic [CharW-1:0] ChUpM    = 16'h004D;
  localparam logic [CharW-1:0] ChUpN    = 16'h004E;
  localparam logic [CharW-1:0] ChUpO    = 16'h004F;
  localparam logic [CharW-1:0] ChUpR    = 16'h0052;
  localparam logic [CharW-1:0] ChUpZ    = 16'h005A;
  localparam logic [CharW-1:0] ChLBr    = 16'h005B;
  localparam logic [CharW-1:0] ChRBr    = 16'h005D;
  localparam logic [CharW-1:0] ChCaret  = 16'h005E;
  localparam logic [CharW-1:0] ChUnder  = 16'h005F;
  localparam logic [CharW-1:0] ChLoA    = 16'h0061;
  localparam logic [CharW-1:0] ChLoZ    = 16'h007A;
  localparam logic [CharW-1:0] ChLBrace = 16'h007B;
  localparam logic [CharW-1:0] ChPipe   = 16'h007C;
  localparam logic [CharW-1:0] ChRBrace = 16'h007D;
  localparam logic [CharW-1:0] ChTilde  = 16'h007E;
  localparam logic [CharW-1:0] ChAsciiMax = 16'h007F;

  typedef enum logic [2:0] {
    KindComment = 3'd0,
    KindNumber  = 3'd1,
    KindVar     = 3'd2,
    KindObject  = 3'd3,
    KindString  = 3'd4,
    KindConst   = 3'd5,
    KindOp      = 3'd6,
    KindText    = 3'd7
  } token_kind_e;

  // classification of one character, computed once in the front end
  typedef struct packed {
    logic space;
    logic digit;
    logic alpha;
    logic varchar;
    logic single_op;
    logic text;
    logic star;
    logic dollar;
    logic lbrace;
    logic rbrace;
    logic apos;
    logic lbr;
    logic rbr;
    logic dash;
    logic gt;
    logic cmp;
    logic eq;
    logic up_a;
    logic up_n;
    logic up_d;
    logic up_o;
    logic up_r;
    logic up_m;
  } char_class_t;

  function automatic char_class_t classify(logic [CharW-1:0] c);
    char_class_t r;
    r.space     = (c inside {[ChTab:ChCr], ChSpace});
    r.digit     = (c inside {[ChZero:ChNine]});
    r.alpha     = (c inside {[ChUpA:ChUpZ], [ChLoA:ChLoZ]}) || (c > ChAsciiMax);
    r.varchar   = r.alpha || r.digit || (c inside {ChDot, ChUnder});
    r.single_op = (c inside {ChTilde, ChPlus, ChStar, ChSlash, ChAmp, ChCaret, ChPipe,
                             ChLParen, ChRParen, ChComma, ChColon, ChRBr});
    r.text      = !(c inside {ChEq, ChLt, ChGt, ChBang, ChDash, ChLBr, ChDollar,
                              ChLBrace, ChRBrace, ChApos})
                  && !r.single_op && !r.space;
    r.star      = (c == ChStar);
    r.dollar    = (c == ChDollar);
    r.lbrace    = (c == ChLBrace);
    r.rbrace    = (c == ChRBrace);
    r.apos      = (c == ChApos);
    r.lbr       = (c == ChLBr);
    r.rbr       = (c == ChRBr);
    r.dash      = (c == ChDash);
    r.gt        = (c == ChGt);
    r.cmp       = (c inside {ChLt, ChGt, ChBang, ChEq});
    r.eq        = (c == ChEq);
    r.up_a      = (c == ChUpA);
    r.up_n      = (c == ChUpN);
    r.up_d      = (c == ChUpD);
    r.up_o      = (c == ChUpO);
    r.up_r      = (c == ChUpR);
    r.up_m      = (c == ChUpM);
    return r;
  endfunction

endpackage

// ----- design/sct_if.sv -----
`timescale 1ns / 1ps

interface sct_char_if;
  logic                           valid;
  logic                           ready;
  logic [sct_pkg::CharW-1:0]      character;
  logic                           line_end;

  modport source (output valid, output character, output line_end, input ready);
  modport sink (input valid, input character, input line_end, output ready);
endinterface

interface sct_tok_if;
  logic                           valid;
  logic                           ready;
  sct_pkg::token_kind_e           token_kind;
  logic [sct_pkg::OutOffW-1:0]    begin_offset;
  logic [sct_pkg::OutOffW-1:0]    end_offset;
  logic                           last_of_item;
  logic                           line_over;

  modport source (output valid, output token_kind, output begin_offset, output end_offset,
                  output last_of_item, output line_over, input ready);
  modport sink (input valid, input token_kind, input begin_offset, input end_offset,
                input last_of_item, input line_over, output ready);
endinterface

// ----- design/sct_queue.sv -----
`timescale 1ns / 1ps

module sct_queue #(
  parameter int unsigned WIDTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  // two entries: one in flight plus one of slack
  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ----- design/sct_front.sv -----
`timescale 1ns / 1ps

module sct_front #(
  parameter int unsigned LINE_MAX  = sct_pkg::LineMaxDefault,
  parameter int unsigned CHAR_BITS = sct_pkg::CharBitsDefault,
  localparam int unsigned OffW     = $clog2(LINE_MAX + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sct_char_if.sink             char_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output sct_pkg::char_class_t cls_o,
  output logic                 last_o,
  output logic [OffW-1:0]      off_o,
  output logic [OffW-1:0]      off_nx_o
);

  localparam int unsigned CharUsed = (CHAR_BITS < sct_pkg::CharW) ? CHAR_BITS : sct_pkg::CharW;
  localparam logic [sct_pkg::CharW-1:0] CharMask = sct_pkg::CharW'((1 << CharUsed) - 1);
  localparam logic [OffW-1:0] OffMax = OffW'(LINE_MAX);

  logic [OffW-1:0] offset_q, offset_d;

  assign char_i.ready = !q_full_i;
  assign push_o       = char_i.valid && !q_full_i;

  // offset within the line, saturating
  assign off_o    = offset_q;
  assign off_nx_o = (offset_q == OffMax) ? offset_q : offset_q + 1'b1;
  assign cls_o    = sct_pkg::classify(char_i.character & CharMask);
  assign last_o   = char_i.line_end;

  always_comb begin
    offset_d = offset_q;
    if (push_o) begin
      offset_d = char_i.line_end ? '0 : off_nx_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
    end else begin
      offset_q <= offset_d;
    end
  end

endmodule

// ----- design/sct_back.sv -----
`timescale 1ns / 1ps

module sct_back #(
  parameter int unsigned LINE_MAX = sct_pkg::LineMaxDefault,
  localparam int unsigned OffW    = $clog2(LINE_MAX + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  output logic                 pop_o,
  input  sct_pkg::char_class_t cls_i,
  input  logic                 last_i,
  input  logic [OffW-1:0]      off_i,
  input  logic [OffW-1:0]      off_nx_i,
  sct_tok_if.source            tok_o
);

  localparam int unsigned OutW = sct_pkg::OutOffW;

  typedef enum logic [15:0] {
    M_IDLE    = 16'h0001,
    M_COMMENT = 16'h0002,
    M_NUMBER  = 16'h0004,
    M_VAR     = 16'h0008,
    M_OBJ     = 16'h0010,
    M_STR     = 16'h0020,
    M_CONST   = 16'h0040,
    M_TEXT    = 16'h0080,
    M_LBR     = 16'h0100,
    M_DASH    = 16'h0200,
    M_CMP     = 16'h0400,
    M_A       = 16'h0800,
    M_AN      = 16'h1000,
    M_O       = 16'h2000,
    M_M       = 16'h4000,
    M_MO      = 16'h8000
  } lex_mode_e;

  typedef struct packed {
    sct_pkg::token_kind_e kind;
    logic [OffW-1:0]      b;
    logic [OffW-1:0]      e;
  } res_t;

  typedef struct packed {
    lex_mode_e       mode;
    logic [OffW-1:0] tb;
    logic [1:0]      til;
    logic            fis;
    logic [1:0]      n;
    res_t [1:0]      res;
  } lex_st_t;

  typedef struct packed {
    sct_pkg::token_kind_e kind;
    logic [OffW-1:0]      b;
    logic [OffW-1:0]      e;
    logic                 lit;
    logic                 lo;
  } out_t;

  function automatic sct_pkg::token_kind_e mode_kind(lex_mode_e m);
    sct_pkg::token_kind_e k;
    case (m)
      M_COMMENT: k = sct_pkg::KindComment;
      M_NUMBER:  k = sct_pkg::KindNumber;
      M_VAR:     k = sct_pkg::KindVar;
      M_OBJ:     k = sct_pkg::KindObject;
      M_STR:     k = sct_pkg::KindString;
      M_CONST:   k = sct_pkg::KindConst;
      M_LBR:     k = sct_pkg::KindOp;
      M_DASH:    k = sct_pkg::KindOp;
      M_CMP:     k = sct_pkg::KindOp;
      default:   k = sct_pkg::KindText;
    endcase
    return k;
  endfunction

  function automatic lex_st_t emit_f(lex_st_t s, sct_pkg::token_kind_e kind,
                                     logic [OffW-1:0] end_off, logic star);
    lex_st_t r;
    r = s;
    if (r.n != 2'd2) begin
      r.res[r.n[0]].kind = kind;
      r.res[r.n[0]].b    = r.tb;
      r.res[r.n[0]].e    = end_off;
      r.n                = r.n + 2'd1;
    end
    if (r.til == 2'd0 && star) begin
      r.fis = 1'b1;
    end
    if (r.til != 2'd3) begin
      r.til = r.til + 2'd1;
    end
    r.mode = M_IDLE;
    return r;
  endfunction

  function automatic lex_st_t start_f(lex_st_t s, sct_pkg::char_class_t c,
                                      logic [OffW-1:0] off, logic [OffW-1:0] nx);
    lex_st_t r;
    r    = s;
    r.tb = off;
    if (c.space) begin
      r.mode = M_IDLE;
    end else if (r.til == 2'd1 && r.fis) begin
      r.mode = M_COMMENT;
    end else if (c.digit) begin
      r.mode = M_NUMBER;
    end else if (c.dollar) begin
      r.mode = M_VAR;
    end else if (c.lbrace) begin
      r.mode = M_OBJ;
    end else if (c.apos) begin
      r.mode = M_STR;
    end else if (c.rbrace) begin
      r = emit_f(r, sct_pkg::KindText, nx, 1'b0);
    end else if (c.lbr) begin
      r.mode = M_LBR;
    end else if (c.dash) begin
      r.mode = M_DASH;
    end else if (c.cmp) begin
      r.mode = M_CMP;
    end else if (c.up_a) begin
      r.mode = M_A;
    end else if (c.up_o) begin
      r.mode = M_O;
    end else if (c.up_m) begin
      r.mode = M_M;
    end else if (c.single_op) begin
      r = emit_f(r, sct_pkg::KindOp, nx, c.star);
    end else begin
      r.mode = M_TEXT;
    end
    return r;
  endfunction

  function automatic lex_st_t close_f(lex_st_t s, sct_pkg::char_class_t c,
                                      logic [OffW-1:0] off, logic [OffW-1:0] nx);
    lex_st_t r;
    r = emit_f(s, mode_kind(s.mode), off, 1'b0);
    r = start_f(r, c, off, nx);
    return r;
  endfunction

  function automatic lex_st_t text_f(lex_st_t s, sct_pkg::char_class_t c,
                                     logic [OffW-1:0] off, logic [OffW-1:0] nx);
    lex_st_t r;
    r      = s;
    r.mode = M_TEXT;
    if (!c.text) begin
      r = close_f(r, c, off, nx);
    end
    return r;
  endfunction

  lex_mode_e       mode_q;
  logic [OffW-1:0] tb_q;
  logic [1:0]      til_q;
  logic            fis_q;
  lex_st_t         st;

  out_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  out_t hold_q, hold_d;
  logic hold_valid_q, hold_valid_d;
  logic free;
  logic take;

  always_comb begin
    st      = '0;
    st.mode = mode_q;
    st.tb   = tb_q;
    st.til  = til_q;
    st.fis  = fis_q;
    case (mode_q)
      M_IDLE:    st = start_f(st, cls_i, off_i, off_nx_i);
      M_COMMENT: st = st;
      M_NUMBER:  if (!cls_i.digit) st = close_f(st, cls_i, off_i, off_nx_i);
      M_VAR:     if (!cls_i.varchar) st = close_f(st, cls_i, off_i, off_nx_i);
      M_OBJ:     if (cls_i.rbrace) st = emit_f(st, sct_pkg::KindObject, off_nx_i, 1'b0);
      M_STR:     if (cls_i.apos) st = emit_f(st, sct_pkg::KindString, off_nx_i, 1'b0);
      M_CONST:   if (cls_i.rbr) st = emit_f(st, sct_pkg::KindConst, off_nx_i, 1'b0);
      M_TEXT:    st = text_f(st, cls_i, off_i, off_nx_i);
      M_LBR: begin
        if (cls_i.alpha) st.mode = M_CONST;
        else st = close_f(st, cls_i, off_i, off_nx_i);
      end
      M_DASH: begin
        if (cls_i.gt) st = emit_f(st, sct_pkg::KindOp, off_nx_i, 1'b0);
        else st = close_f(st, cls_i, off_i, off_nx_i);
      end
      M_CMP: begin
        if (cls_i.eq) st = emit_f(st, sct_pkg::KindOp, off_nx_i, 1'b0);
        else st = close_f(st, cls_i, off_i, off_nx_i);
      end
      M_A: begin
        if (cls_i.up_n) st.mode = M_AN;
        else st = text_f(st, cls_i, off_i, off_nx_i);
      end
      M_AN: begin
        if (cls_i.up_d) st = emit_f(st, sct_pkg::KindOp, off_nx_i, 1'b0);
        else st = text_f(st, cls_i, off_i, off_nx_i);
      end
      M_O: begin
        if (cls_i.up_r) st = emit_f(st, sct_pkg::KindOp, off_nx_i, 1'b0);
        else st = text_f(st, cls_i, off_i, off_nx_i);
      end
      M_M: begin
        if (cls_i.up_o) st.mode = M_MO;
        else st = text_f(st, cls_i, off_i, off_nx_i);
      end
      M_MO: begin
        if (cls_i.up_d) st = emit_f(st, sct_pkg::KindOp, off_nx_i, 1'b0);
        else st = text_f(st, cls_i, off_i, off_nx_i);
      end
      default:   st.mode = M_IDLE;
    endcase
    // line end closes whatever is open and clears the line state
    if (last_i) begin
      if (st.mode != M_IDLE) begin
        st = emit_f(st, mode_kind(st.mode), off_nx_i, 1'b0);
      end
      st.mode = M_IDLE;
      st.tb   = '0;
      st.til  = 2'd0;
      st.fis  = 1'b0;
    end
  end

  // output register plus one spare for a second token of the same character
  assign free  = !out_valid_q || tok_o.ready;
  assign take  = free && !hold_valid_q && item_valid_i;
  assign pop_o = take;

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    hold_d       = hold_q;
    hold_valid_d = hold_valid_q;
    if (free) begin
      if (hold_valid_q) begin
        out_d        = hold_q;
        out_valid_d  = 1'b1;
        hold_valid_d = 1'b0;
      end else if (take) begin
        out_d.kind   = st.res[0].kind;
        out_d.b      = st.res[0].b;
        out_d.e      = st.res[0].e;
        out_d.lit    = (st.n == 2'd1);
        out_d.lo     = (st.n == 2'd1) && last_i;
        out_valid_d  = (st.n != 2'd0);
        hold_d.kind  = st.res[1].kind;
        hold_d.b     = st.res[1].b;
        hold_d.e     = st.res[1].e;
        hold_d.lit   = 1'b1;
        hold_d.lo    = last_i;
        hold_valid_d = (st.n == 2'd2);
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= M_IDLE;
      tb_q         <= '0;
      til_q        <= 2'd0;
      fis_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      hold_valid_q <= 1'b0;
    end else begin
      if (take) begin
        mode_q <= st.mode;
        tb_q   <= st.tb;
        til_q  <= st.til;
        fis_q  <= st.fis;
      end
      out_valid_q  <= out_valid_d;
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    hold_q <= hold_d;
  end

  assign tok_o.valid        = out_valid_q;
  assign tok_o.token_kind   = out_q.kind;
  assign tok_o.begin_offset = OutW'(out_q.b);
  assign tok_o.end_offset   = OutW'(out_q.e);
  assign tok_o.last_of_item = out_q.lit;
  assign tok_o.line_over    = out_q.lo;

endmodule

// ----- design/script_command_tokenizer.sv -----
`timescale 1ns / 1ps

// channel | dir | payload                                                     | handshake
// char_i  | in  | character, line_end                                         | valid/ready
// tok_o   | out | token_kind, begin_offset, end_offset, last_of_item, line_over | valid/ready
//
// one character is accepted per cycle while the queue has room; a character that yields two
// tokens holds the back end until the spare token moves on, as the output register delivers
// one token a cycle while the receiver is ready; tokens are registered after the queue
// reset clears the line offset, the lexer state, the queue and both output valids
// input ready falls only when the two-entry queue is full; an output stall fills it

module script_command_tokenizer #(
  parameter int unsigned LINE_MAX  = sct_pkg::LineMaxDefault,
  parameter int unsigned CHAR_BITS = sct_pkg::CharBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sct_char_if.sink  char_i,
  sct_tok_if.source tok_o
);

  // offsets saturate at LINE_MAX, so they need enough bits to hold it
  localparam int unsigned OffW  = $clog2(LINE_MAX + 1);
  localparam int unsigned ClsW  = $bits(sct_pkg::char_class_t);
  localparam int unsigned ItemW = ClsW + 1 + 2 * OffW;

  // front end outputs: classified character with its offsets
  sct_pkg::char_class_t f_cls;
  logic                 f_last;
  logic [OffW-1:0]      f_off;
  logic [OffW-1:0]      f_off_nx;
  logic                 f_push;

  // queue between classification and lexing
  logic [ItemW-1:0]     q_wdata;
  logic [ItemW-1:0]     q_rdata;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;

  // back end view of the queue head
  sct_pkg::char_class_t b_cls;
  logic                 b_last;
  logic [OffW-1:0]      b_off;
  logic [OffW-1:0]      b_off_nx;

  // front: takes the transaction, masks and classifies the character, counts offsets
  sct_front #(
    .LINE_MAX  (LINE_MAX),
    .CHAR_BITS (CHAR_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (char_i),
    .q_full_i (q_full),
    .push_o   (f_push),
    .cls_o    (f_cls),
    .last_o   (f_last),
    .off_o    (f_off),
    .off_nx_o (f_off_nx)
  );

  assign q_wdata = {f_cls, f_last, f_off, f_off_nx};

  sct_queue #(
    .WIDTH (ItemW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  assign {b_cls, b_last, b_off, b_off_nx} = q_rdata;

  // back: lexer state machine, token output register and spare slot
  sct_back #(
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!q_empty),
    .pop_o        (q_pop),
    .cls_i        (b_cls),
    .last_i       (b_last),
    .off_i        (b_off),
    .off_nx_i     (b_off_nx),
    .tok_o        (tok_o)
  );

endmodule

// ----- bench/script_command_tokenizer_tb.sv -----
`timescale 1ns / 1ps

import sct_pkg::*;

// lexer modes of the predictor, one per kind of open token or pending prefix
typedef enum logic [3:0] {
  LxIdle, LxComment, LxNumber, LxVar, LxObj, LxStr, LxConst, LxText,
  LxLbr, LxDash, LxCmp, LxA, LxAn, LxO, LxM, LxMo
} lex_mode_e;

typedef struct {
  token_kind_e        kind;
  logic [OutOffW-1:0] begin_off;
  logic [OutOffW-1:0] end_off;
  logic               last_of_item;
  logic               line_over;
} token_t;

// predicts the tokens of each accepted character and checks the ones that leave the block
class token_tracker;
  lex_mode_e   mode;
  int unsigned tok_begin;
  int unsigned offset;
  int unsigned tok_count;
  bit          star_first;
  token_t      char_tokens[$];
  token_t      tokens_due[$];
  int          mismatches;

  function new();
    mode       = LxIdle;
    tok_begin  = 0;
    offset     = 0;
    tok_count  = 0;
    star_first = 1'b0;
    mismatches = 0;
  endfunction

  function bit is_space(logic [CharW-1:0] c);
    return (c >= ChTab && c <= ChCr) || c == ChSpace;
  endfunction

  function bit is_digit(logic [CharW-1:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function bit is_alpha(logic [CharW-1:0] c);
    return (c >= ChUpA && c <= ChUpZ) || (c >= ChLoA && c <= ChLoZ) || c > ChAsciiMax;
  endfunction

  function bit is_varchar(logic [CharW-1:0] c);
    return is_alpha(c) || is_digit(c) || c == ChDot || c == ChUnder;
  endfunction

  function bit is_single_op(logic [CharW-1:0] c);
    case (c)
      ChTilde, ChPlus, ChStar, ChSlash, ChAmp, ChCaret, ChPipe,
      ChLParen, ChRParen, ChComma, ChColon, ChRBr: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function bit is_text(logic [CharW-1:0] c);
    case (c)
      ChEq, ChLt, ChGt, ChBang, ChDash, ChLBr,
      ChDollar, ChLBrace, ChRBrace, ChApos: return 1'b0;
      default: return !is_single_op(c) && !is_space(c);
    endcase
  endfunction

  function int unsigned sat_next(int unsigned off);
    return (off + 1 > LineMaxDefault) ? LineMaxDefault : off + 1;
  endfunction

  function token_kind_e kind_of(lex_mode_e m);
    case (m)
      LxComment:            return KindComment;
      LxNumber:             return KindNumber;
      LxVar:                return KindVar;
      LxObj:                return KindObject;
      LxStr:                return KindString;
      LxConst:              return KindConst;
      LxLbr, LxDash, LxCmp: return KindOp;
      default:              return KindText;
    endcase
  endfunction

  // closes the open token; a star as first token of a line turns the rest into a comment
  function void emit(token_kind_e kind, int unsigned end_at, bit is_star);
    token_t t;
    if (char_tokens.size() < 2) begin
      t.kind         = kind;
      t.begin_off    = tok_begin[OutOffW-1:0];
      t.end_off      = end_at[OutOffW-1:0];
      t.last_of_item = 1'b0;
      t.line_over    = 1'b0;
      char_tokens.insert(char_tokens.size(), t);
    end
    if (tok_count == 0 && is_star) star_first = 1'b1;
    if (tok_count < 3) tok_count++;
    mode = LxIdle;
  endfunction

  function void start(logic [CharW-1:0] c, int unsigned off);
    tok_begin = off;
    if (is_space(c)) begin
      mode = LxIdle;
      return;
    end
    if (tok_count == 1 && star_first) begin
      mode = LxComment;
      return;
    end
    if (is_digit(c)) begin
      mode = LxNumber;
      return;
    end
    case (c)
      ChDollar:                 mode = LxVar;
      ChLBrace:                 mode = LxObj;
      ChApos:                   mode = LxStr;
      ChRBrace:                 emit(KindText, sat_next(off), 1'b0);
      ChLBr:                    mode = LxLbr;
      ChDash:                   mode = LxDash;
      ChLt, ChGt, ChBang, ChEq: mode = LxCmp;
      ChUpA:                    mode = LxA;
      ChUpO:                    mode = LxO;
      ChUpM:                    mode = LxM;
      default: begin
        if (is_single_op(c)) emit(KindOp, sat_next(off), c == ChStar);
        else mode = LxText;
      end
    endcase
  endfunction

  function void close_restart(logic [CharW-1:0] c, int unsigned off);
    emit(kind_of(mode), off, 1'b0);
    start(c, off);
  endfunction

  function void text_char(logic [CharW-1:0] c, int unsigned off);
    mode = LxText;
    if (!is_text(c)) close_restart(c, off);
  endfunction

  function void step(logic [CharW-1:0] c, int unsigned off);
    case (mode)
      LxIdle:    start(c, off);
      LxComment: ;
      LxNumber:  if (!is_digit(c)) close_restart(c, off);
      LxVar:     if (!is_varchar(c)) close_restart(c, off);
      LxObj:     if (c == ChRBrace) emit(KindObject, sat_next(off), 1'b0);
      LxStr:     if (c == ChApos) emit(KindString, sat_next(off), 1'b0);
      LxConst:   if (c == ChRBr) emit(KindConst, sat_next(off), 1'b0);
      LxText:    text_char(c, off);
      LxLbr:     if (is_alpha(c)) mode = LxConst; else close_restart(c, off);
      LxDash:    if (c == ChGt) emit(KindOp, sat_next(off), 1'b0); else close_restart(c, off);
      LxCmp:     if (c == ChEq) emit(KindOp, sat_next(off), 1'b0); else close_restart(c, off);
      LxA:       if (c == ChUpN) mode = LxAn; else text_char(c, off);
      LxAn:      if (c == ChUpD) emit(KindOp, sat_next(off), 1'b0); else text_char(c, off);
      LxO:       if (c == ChUpR) emit(KindOp, sat_next(off), 1'b0); else text_char(c, off);
      LxM:       if (c == ChUpO) mode = LxMo; else text_char(c, off);
      LxMo:      if (c == ChUpD) emit(KindOp, sat_next(off), 1'b0); else text_char(c, off);
      default:   mode = LxIdle;
    endcase
  endfunction

  // one accepted character transaction: queue the tokens it completes
  function void note_char(logic [CharW-1:0] c, logic line_end);
    int unsigned off;
    token_t      t;
    off = (offset > LineMaxDefault) ? LineMaxDefault : offset;
    char_tokens.delete();
    step(c, off);
    if (line_end) begin
      // whatever is still open ends with the line
      if (mode != LxIdle) emit(kind_of(mode), sat_next(off), 1'b0);
      mode       = LxIdle;
      tok_begin  = 0;
      offset     = 0;
      tok_count  = 0;
      star_first = 1'b0;
    end else begin
      offset = sat_next(off);
    end
    foreach (char_tokens[k]) begin
      t              = char_tokens[k];
      t.last_of_item = (k == char_tokens.size() - 1);
      t.line_over    = t.last_of_item && line_end;
      tokens_due.insert(tokens_due.size(), t);
    end
  endfunction

  task report(string msg);
    mismatches++;
    $display("mismatch: %s", msg);
  endtask

  task check_token(token_kind_e kind, logic [OutOffW-1:0] b, logic [OutOffW-1:0] e,
                   logic l, logic o);
    token_t w;
    if (tokens_due.size() == 0) begin
      report($sformatf("token kind %0d [%0d,%0d) with none due", kind, b, e));
      return;
    end
    w = tokens_due.pop_front();
    if (kind !== w.kind)
      report($sformatf("kind %0d, want %0d (begin %0d)", kind, w.kind, w.begin_off));
    if (b !== w.begin_off)
      report($sformatf("begin_offset %0d, want %0d", b, w.begin_off));
    if (e !== w.end_off)
      report($sformatf("end_offset %0d, want %0d (begin %0d)", e, w.end_off, w.begin_off));
    if (l !== w.last_of_item)
      report($sformatf("last_of_item %0b, want %0b (begin %0d)", l, w.last_of_item,
                       w.begin_off));
    if (o !== w.line_over)
      report($sformatf("line_over %0b, want %0b (begin %0d)", o, w.line_over, w.begin_off));
  endtask
endclass

module script_command_tokenizer_tb;

  // stimulus phases, each with its own idling pattern
  typedef enum logic [2:0] {
    PhSteady, PhSendGaps, PhRecvStalls, PhBothGaps, PhPressure
  } phase_e;

  localparam int unsigned      QuietLimit  = 2000;  // cycles with no transaction at all
  localparam int unsigned      LongHold    = 300;   // receiver hold-off under pressure
  localparam int unsigned      PhaseItems  = 85;    // characters per random phase, at least
  localparam int unsigned      DrainCycles = 8;
  localparam logic [CharW-1:0] CharNul     = '0;
  localparam logic [CharW-1:0] CharTop     = '1;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sct_char_if ch ();
  sct_tok_if  tk ();

  token_tracker tracker = new();

  phase_e      phase      = PhSteady;
  int unsigned send_idle  = 0;   // percent of cycles the sender holds back
  int unsigned recv_stall = 0;   // percent of cycles the receiver stalls

  logic [CharW-1:0] line_buf[$];

  script_command_tokenizer #(
    .LINE_MAX (LineMaxDefault),
    .CHAR_BITS(CharBitsDefault)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .char_i(ch),
    .tok_o (tk)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // character generators
  // ---------------------------------------------------------------------------

  function automatic void add_char(logic [CharW-1:0] c);
    line_buf.insert(line_buf.size(), c);
  endfunction

  function automatic logic [CharW-1:0] any_char();
    logic [CharW-1:0] r;
    r = CharW'($urandom);
    return r;
  endfunction

  // ascii letters of both cases, and code units above ascii, which also count as letters
  function automatic logic [CharW-1:0] rand_letter();
    case ($urandom_range(2))
      0:       return CharW'(ChUpA + $urandom_range(ChUpZ - ChUpA));
      1:       return CharW'(ChLoA + $urandom_range(ChLoZ - ChLoA));
      default: return CharW'($urandom_range(CharTop, ChAsciiMax + 1));
    endcase
  endfunction

  function automatic logic [CharW-1:0] rand_digit();
    return CharW'(ChZero + $urandom_range(ChNine - ChZero));
  endfunction

  function automatic logic [CharW-1:0] rand_space();
    if ($urandom_range(1)) return ChSpace;
    return CharW'(ChTab + $urandom_range(ChCr - ChTab));
  endfunction

  function automatic logic [CharW-1:0] rand_single_op();
    case ($urandom_range(11))
      0:       return ChTilde;
      1:       return ChPlus;
      2:       return ChStar;
      3:       return ChSlash;
      4:       return ChAmp;
      5:       return ChCaret;
      6:       return ChPipe;
      7:       return ChLParen;
      8:       return ChRParen;
      9:       return ChComma;
      10:      return ChColon;
      default: return ChRBr;
    endcase
  endfunction

  function automatic logic [CharW-1:0] rand_cmp();
    case ($urandom_range(3))
      0:       return ChLt;
      1:       return ChGt;
      2:       return ChBang;
      default: return ChEq;
    endcase
  endfunction

  function automatic logic [CharW-1:0] rand_varchar();
    case ($urandom_range(3))
      0:       return rand_letter();
      1:       return rand_digit();
      2:       return ChDot;
      default: return ChUnder;
    endcase
  endfunction

  // inside of a brace, quote or bracket token; never its own closing character
  function automatic logic [CharW-1:0] rand_body(logic [CharW-1:0] closer);
    logic [CharW-1:0] c;
    case ($urandom_range(4))
      0:       c = rand_letter();
      1:       c = rand_digit();
      2:       c = rand_space();
      3:       c = rand_single_op();
      default: c = any_char();
    endcase
    if (c == closer) c = ChDot;
    return c;
  endfunction

  // appends one mostly well-formed token, a prefix of one, or noise
  function automatic void add_piece();
    case ($urandom_range(15))
      0: repeat ($urandom_range(4, 1)) add_char(rand_digit());
      1: begin
        add_char(ChDollar);
        repeat ($urandom_range(3)) add_char(rand_varchar());
      end
      2: begin
        add_char(ChLBrace);
        repeat ($urandom_range(4)) add_char(rand_body(ChRBrace));
        if ($urandom_range(5) != 0) add_char(ChRBrace);
      end
      3: begin
        add_char(ChApos);
        repeat ($urandom_range(4)) add_char(rand_body(ChApos));
        if ($urandom_range(5) != 0) add_char(ChApos);
      end
      4: begin
        // script constant: bracket, letter, body, mostly a closing bracket
        add_char(ChLBr);
        add_char(rand_letter());
        repeat ($urandom_range(3)) add_char(rand_body(ChRBr));
        if ($urandom_range(5) != 0) add_char(ChRBr);
      end
      5: begin
        // bracket without a letter behind it is an operator
        add_char(ChLBr);
        case ($urandom_range(3))
          0:       add_char(rand_digit());
          1:       add_char(rand_space());
          2:       add_char(rand_single_op());
          default: add_char(ChDollar);
        endcase
      end
      6: begin
        add_char(ChDash);
        if ($urandom_range(1)) add_char(ChGt);
      end
      7: begin
        add_char(rand_cmp());
        if ($urandom_range(1)) add_char(ChEq);
      end
      8: add_char(rand_single_op());
      9: begin
        // word operators, whole or cut short, sometimes with letters behind
        case ($urandom_range(7))
          0: begin
            add_char(ChUpA);
            add_char(ChUpN);
            add_char(ChUpD);
          end
          1: begin
            add_char(ChUpO);
            add_char(ChUpR);
          end
          2: begin
            add_char(ChUpM);
            add_char(ChUpO);
            add_char(ChUpD);
          end
          3: add_char(ChUpA);
          4: begin
            add_char(ChUpA);
            add_char(ChUpN);
          end
          5: add_char(ChUpO);
          6: add_char(ChUpM);
          default: begin
            add_char(ChUpM);
            add_char(ChUpO);
          end
        endcase
        if ($urandom_range(2) == 0) add_char(rand_letter());
      end
      10: begin
        add_char(rand_letter());
        repeat ($urandom_range(3)) add_char(rand_varchar());
      end
      11: add_char(ChRBrace);
      12: add_char(ChStar);
      13: add_char(any_char());
      default: repeat ($urandom_range(2, 1)) add_char(rand_space());
    endcase
  endfunction

  // a random line; some open with a star so the rest becomes a comment
  function automatic void build_line(int unsigned pieces);
    line_buf.delete();
    if ($urandom_range(7) == 0) begin
      if ($urandom_range(1)) add_char(rand_space());
      add_char(ChStar);
    end
    repeat (pieces) begin
      add_piece();
      if ($urandom_range(1)) add_char(rand_space());
    end
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offers one character and waits for the transaction
  task automatic send_char(logic [CharW-1:0] c, logic last);
    while ($urandom_range(99) < send_idle) begin
      ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    ch.valid     <= 1'b1;
    ch.character <= c;
    ch.line_end  <= last;
    @(posedge clk_i);
    while (!ch.ready) @(posedge clk_i);
    tracker.note_char(c, last);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: random stalls, plus one long hold-off in the pressure phase
  // ---------------------------------------------------------------------------

  initial begin : token_sink
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    tk.ready  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (phase == PhPressure && !held) begin
        held      = 1'b1;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        tk.ready <= 1'b0;
      end else begin
        tk.ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // every token transaction is checked against the oldest predicted token
  always @(posedge clk_i) begin
    if (rst_ni && tk.valid === 1'b1 && tk.ready === 1'b1)
      tracker.check_token(tk.token_kind, tk.begin_offset, tk.end_offset,
                          tk.last_of_item, tk.line_over);
  end

  // ends a hung run: too long without a transaction on either side
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((ch.valid === 1'b1 && ch.ready === 1'b1) || (tk.valid === 1'b1 && tk.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("script_command_tokenizer_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    int unsigned sent;
    ch.valid     = 1'b0;
    ch.character = '0;
    ch.line_end  = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // star as first token, then a comment up to the line end
    line_buf = '{ChStar, ChLoA, ChSpace, ChNine};
    send_line();
    // nul as text, a variable closed by an operator (two tokens), lone dollar at the end
    line_buf = '{CharNul, ChDollar, ChLoA, ChLParen, ChDollar};
    send_line();
    // lone closing brace, then an empty game object
    line_buf = '{ChRBrace, ChLBrace, ChRBrace};
    send_line();
    // constant, then an opening bracket left pending at the line end
    line_buf = '{ChLBr, ChLoA, ChRBr, ChLBr};
    send_line();
    // OR and AND back to back
    line_buf = '{ChUpO, ChUpR, ChUpA, ChUpN, ChUpD};
    send_line();
    // MOD, arrow, and the top code unit as text at the line end
    line_buf = '{ChUpM, ChUpO, ChUpD, ChDash, ChGt, CharTop};
    send_line();
    // whitespace only: no token at all
    line_buf = '{ChSpace};
    send_line();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin phase = PhSteady;     send_idle = 0;  recv_stall = 0;  end
        1: begin phase = PhSendGaps;   send_idle = 48; recv_stall = 0;  end
        2: begin phase = PhRecvStalls; send_idle = 0;  recv_stall = 48; end
        3: begin phase = PhBothGaps;   send_idle = 15; recv_stall = 15; end
        default: begin phase = PhPressure; send_idle = 0; recv_stall = 10; end
      endcase
      sent = 0;
      while (sent < PhaseItems) begin
        build_line($urandom_range(8, 1));
        if (line_buf.size() == 0) add_char(rand_space());
        send_line();
        sent += line_buf.size();
      end
    end

    // one line past the offset limit, so offsets saturate
    build_line(1);
    while (line_buf.size() < LineMaxDefault + 16) add_piece();
    send_line();

    ch.valid <= 1'b0;
    while (tracker.tokens_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (tracker.mismatches == 0)
      $display("script_command_tokenizer_tb OK");
    else
      $display("script_command_tokenizer_tb NOT OK");
    $finish;
  end

endmodule

// ----- script_command_tokenizer.f -----
design/sct_pkg.sv
design/sct_if.sv
design/sct_queue.sv
design/sct_front.sv
design/sct_back.sv
design/script_command_tokenizer.sv
bench/script_command_tokenizer_tb.sv
